### rtl/core/entropy_seeded_lcg_xorshift_rng_macros.svh
// ----------------------------------------------------------------------------
// entropy_seeded_lcg_xorshift_rng assertion macros
// concurrent assertion helpers shared by the rng core
// ----------------------------------------------------------------------------
`ifndef ENTROPY_SEEDED_LCG_XORSHIFT_RNG_MACROS_SVH
`define ENTROPY_SEEDED_LCG_XORSHIFT_RNG_MACROS_SVH

// same-cycle implication, disabled during reset
`define ESRNG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esrng assertion failed");

// next-cycle implication, disabled during reset
`define ESRNG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("esrng assertion failed");

`endif

### rtl/core/esrng_pkg.sv
// ----------------------------------------------------------------------------
// esrng_pkg
// constants and types shared by the entropy seeded rng core
// ----------------------------------------------------------------------------
package esrng_pkg;

    localparam logic [31:0] SEED_RESET    = 32'h1234_5678;
    localparam logic [31:0] SEED_FALLBACK = 32'h5EED_5EED;
    localparam logic [31:0] LCG_MUL       = 32'd1103515245;
    localparam logic [31:0] LCG_ADD       = 32'd12345;

    localparam int XS_SHL_A = 13;
    localparam int XS_SHR_B = 17;
    localparam int XS_SHL_C = 5;

    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_GEN  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [9:0] adc_sample;
        logic [7:0] timer0_count;
        logic [15:0] timer1_count;
        logic [7:0] timer2_count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] seed_next;
        logic [31:0] pool_next;
        logic [7:0]  rand_byte;
        logic        byte_valid;
        logic        reseeded;
    } t_step;

endpackage

### rtl/core/esrng_mix.sv
// ----------------------------------------------------------------------------
// esrng_mix
// one-step datapath: noise word, lcg + xorshift, pool fold and reseed select
// ----------------------------------------------------------------------------
module esrng_mix (
    input  esrng_pkg::t_in_item i_item,
    input  logic [31:0]         i_seed,
    input  logic [31:0]         i_pool,
    input  logic                i_pool_full,
    output esrng_pkg::t_step    o_step
);

    logic [31:0] noise;
    logic [31:0] lcg;
    logic [31:0] xs_a;
    logic [31:0] xs_b;
    logic [31:0] xs_c;
    logic [31:0] pool_mix;
    logic [31:0] pool_rot;
    logic        is_gen;

    assign noise = {22'd0, i_item.adc_sample}
                 ^ {8'd0, i_item.timer0_count, 16'd0}
                 ^ {8'd0, i_item.timer1_count, 8'd0}
                 ^ {24'd0, i_item.timer2_count};

    // low 32 bits of the product only
    assign lcg  = (i_seed * esrng_pkg::LCG_MUL + esrng_pkg::LCG_ADD) ^ noise;
    assign xs_a = lcg  ^ (lcg  << esrng_pkg::XS_SHL_A);
    assign xs_b = xs_a ^ (xs_a >> esrng_pkg::XS_SHR_B);
    assign xs_c = xs_b ^ (xs_b << esrng_pkg::XS_SHL_C);

    assign pool_mix = i_pool ^ noise;
    assign pool_rot = {pool_mix[30:0], pool_mix[31]};

    assign is_gen = (i_item.func == esrng_pkg::FUNC_GEN);

    always_comb begin
        o_step = '0;
        if (is_gen) begin
            o_step.seed_next  = xs_c;
            o_step.pool_next  = i_pool;
            o_step.rand_byte  = xs_c[31:24];
            o_step.byte_valid = 1'b1;
        end else if (i_pool_full) begin
            o_step.seed_next = (pool_rot != 32'd0) ? pool_rot : esrng_pkg::SEED_FALLBACK;
            o_step.pool_next = 32'd0;
            o_step.reseeded  = 1'b1;
        end else begin
            o_step.seed_next = i_seed;
            o_step.pool_next = pool_rot;
        end
    end

endmodule

### rtl/core/entropy_seeded_lcg_xorshift_rng.sv
// ----------------------------------------------------------------------------
// entropy_seeded_lcg_xorshift_rng
// byte random generator seeded from converter and timer noise
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_stall    | func, adc_sample, timer counts
//   output  | out       | o_out_valid / i_out_stall  | rand_byte, byte_valid, reseeded
//
// one transaction per cycle unless the output stalls; input then result register
// the seed, pool and count loop closes through the combinational mix logic
// i_rst_n is synchronous: seed 0x12345678, pool and count cleared, both stages empty
// an output stall holds the result register, the input register fills, then
// o_in_stall rises
// ----------------------------------------------------------------------------
`include "entropy_seeded_lcg_xorshift_rng_macros.svh"

module entropy_seeded_lcg_xorshift_rng #(
    parameter int SEED_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [9:0]  i_adc_sample,
    input  logic [7:0]  i_timer0_count,
    input  logic [15:0] i_timer1_count,
    input  logic [7:0]  i_timer2_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_rand_byte,
    output logic        o_byte_valid,
    output logic        o_reseeded
);

    localparam int CNT_W = (SEED_SAMPLES > 1) ? $clog2(SEED_SAMPLES) : 1;

    esrng_pkg::t_in_item r_in;
    logic                r_in_valid;
    logic                r_out_valid;
    logic [7:0]          r_rand_byte;
    logic                r_byte_valid;
    logic                r_reseeded;
    logic [31:0]         r_seed;
    logic [31:0]         r_pool;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    esrng_pkg::t_step    step;
    logic [CNT_W:0]      count_inc;
    logic                pool_full;
    logic                advance;
    logic                in_take;

    assign advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take = i_in_valid && !o_in_stall;

    assign count_inc = {1'b0, r_count} + (CNT_W+1)'(1);
    assign pool_full = (count_inc >= (CNT_W+1)'(SEED_SAMPLES));

    always_comb begin
        n_count = r_count;
        if (r_in.func == esrng_pkg::FUNC_SEED) begin
            n_count = pool_full ? '0 : count_inc[CNT_W-1:0];
        end
    end

    esrng_mix u_mix (
        .i_item      (r_in),
        .i_seed      (r_seed),
        .i_pool      (r_pool),
        .i_pool_full (pool_full),
        .o_step      (step)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func         <= i_func;
            r_in.adc_sample   <= i_adc_sample;
            r_in.timer0_count <= i_timer0_count;
            r_in.timer1_count <= i_timer1_count;
            r_in.timer2_count <= i_timer2_count;
        end
    end

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= esrng_pkg::SEED_RESET;
            r_pool  <= 32'd0;
            r_count <= '0;
        end else if (advance) begin
            r_seed  <= step.seed_next;
            r_pool  <= step.pool_next;
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rand_byte  <= step.rand_byte;
            r_byte_valid <= step.byte_valid;
            r_reseeded   <= step.reseeded;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rand_byte  = r_rand_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_reseeded   = r_reseeded;

    `ESRNG_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, r_out_valid, !(r_byte_valid && r_reseeded))
    `ESRNG_ASSERT_NOW(a_seed_byte_zero, i_clk, i_rst_n, r_out_valid && !r_byte_valid, r_rand_byte == 8'd0)
    `ESRNG_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, {1'b0, r_count} < (CNT_W+1)'(SEED_SAMPLES))
    `ESRNG_ASSERT_NEXT(a_reseed_clears, i_clk, i_rst_n, advance && step.reseeded, (r_pool == 32'd0) && (r_count == '0) && o_reseeded)
    `ESRNG_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule
